/* src/rau_pkg.sv */
// shared types, operation codes and status codes for the rational arithmetic unit
`default_nettype none
package rau_pkg;
   localparam int WordBitsDefault = 32;
   localparam int WideBits = 64;

   typedef enum logic [2:0] {
      OP_NORM = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_CMP  = 3'd5,
      OP_SPLIT = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_OVF  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_COMBINE,
      S_GCD,
      S_DIVIDE,
      S_SPLIT,
      S_CHECK,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

/* src/rau_if.sv */
// valid/ready channel interface with a generic payload
`default_nettype none
interface rau_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/rau_gcd.sv */
// binary gcd of two 64-bit magnitudes, one step per cycle
`default_nettype none
module rau_gcd (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rau_pkg::WideBits-1:0]  x_value,
   input  wire logic [rau_pkg::WideBits-1:0]  y_value,
   output logic                               done,
   output logic [rau_pkg::WideBits-1:0]       gcd_value
);
   import rau_pkg::*;

   logic [WideBits-1:0] u_ff, u_in, v_ff, v_in;
   logic [6:0] shift_ff, shift_in;
   logic busy_ff, busy_in;

   // one binary gcd step: strip common twos or a lone two, else subtract smaller from larger and halve
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      shift_in = shift_ff;
      busy_in = busy_ff;
      if (start) begin
         u_in = x_value;
         v_in = y_value;
         shift_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (u_ff == '0 || v_ff == '0) begin
            busy_in = 1'b0;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            shift_in = shift_ff + 7'd1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = (u_ff - v_ff) >> 1;
         end else begin
            v_in = (v_ff - u_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      shift_ff <= shift_in;
   end

   assign done = busy_ff && (u_ff == '0 || v_ff == '0);
   assign gcd_value = (u_ff | v_ff) << shift_ff[5:0];
endmodule
`default_nettype wire

/* src/rau_div.sv */
// restoring divider for 64-bit magnitudes, one quotient bit per cycle
`default_nettype none
module rau_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rau_pkg::WideBits-1:0]  dividend,
   input  wire logic [rau_pkg::WideBits-1:0]  divisor,
   output logic                               done,
   output logic [rau_pkg::WideBits-1:0]       quotient,
   output logic [rau_pkg::WideBits-1:0]       remainder
);
   import rau_pkg::*;

   logic [WideBits-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic [WideBits:0] trial;

   // shift in one dividend bit and try a subtract
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[WideBits-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         count_in = 7'(WideBits);
         busy_in = 1'b1;
      end else if (busy_ff && count_ff != '0) begin
         count_in = count_ff - 7'd1;
         if (!trial[WideBits]) begin
            r_in = trial[WideBits-1:0];
            q_in = {q_ff[WideBits-2:0], 1'b1};
         end else begin
            r_in = {r_ff[WideBits-2:0], q_ff[WideBits-1]};
            q_in = {q_ff[WideBits-2:0], 1'b0};
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      count_ff <= count_in;
   end

   assign done = busy_ff && count_ff == '0;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// top level of the rational arithmetic unit: sequencer, shared multiplier, gcd and divider
//
//  channel | dir | fields
//  req     | in  | operation, a_num, a_den, b_num, b_den
//  rsp     | out | res_num, res_den, int_part, status, less, equal
//
// one request at a time; req_ready is high only while the sequencer is idle
// a compare runs S_MUL1, S_MUL2 and S_COMBINE, then S_DONE; an error or unused code
// goes straight to S_DONE; a reduce runs the shared 32x32 multiplier, then the binary
// gcd (one step per cycle) and two bit-serial divider passes; a split adds a third
// divider pass
// the result waits in the output register until rsp_ready; no new request meanwhile
// reset is synchronous and clears only control state
`default_nettype none
module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WordBitsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   rau_if.sink       req,
   rau_if.source     rsp
);
   import rau_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [WideBits-1:0] Lim = WideBits'(1) << (W - 1);

   state_type state_ff, state_in;

   logic [2:0] op_ff;
   logic an_ff, bn_ff;
   logic [31:0] am_ff, ad_ff, bm_ff, bd_ff;
   logic [WideBits-1:0] p_ff, q_ff, m_ff, d_ff, g_ff, qm_ff;
   logic neg_ff;
   logic [1:0] divstep_ff;
   status_type st_ff;
   logic [31:0] res_num_ff, int_ff;
   logic [30:0] res_den_ff;
   logic lt_ff, eq_ff, valid_ff;
   logic gcd_start_ff;

   // operand sign extension and sign-magnitude
   logic signed [W-1:0] an_w, ad_w, bn_w, bd_w;
   logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;
   logic an_neg, ad_neg, bn_neg, bd_neg, uses_b;
   always_comb begin
      an_w = req.payload.a_num[W-1:0];
      ad_w = req.payload.a_den[W-1:0];
      bn_w = req.payload.b_num[W-1:0];
      bd_w = req.payload.b_den[W-1:0];
      an_neg = an_w[W-1];
      ad_neg = ad_w[W-1];
      bn_neg = bn_w[W-1];
      bd_neg = bd_w[W-1];
      an_mag = an_neg ? 32'(-{{(33-W){an_w[W-1]}}, an_w}) : 32'(an_w);
      ad_mag = ad_neg ? 32'(-{{(33-W){ad_w[W-1]}}, ad_w}) : 32'(ad_w);
      bn_mag = bn_neg ? 32'(-{{(33-W){bn_w[W-1]}}, bn_w}) : 32'(bn_w);
      bd_mag = bd_neg ? 32'(-{{(33-W){bd_w[W-1]}}, bd_w}) : 32'(bd_w);
      uses_b = req.payload.operation >= OP_ADD && req.payload.operation <= OP_CMP;
   end

   // shared multiplier, operands picked by state
   logic [31:0] mul_x, mul_y;
   logic [WideBits-1:0] mul_p;
   always_comb begin
      mul_x = am_ff;
      mul_y = bd_ff;
      case (state_ff)
         S_MUL1: begin
            mul_x = (op_ff == OP_MUL) ? am_ff : am_ff;
            mul_y = (op_ff == OP_MUL) ? bm_ff : bd_ff;
         end
         S_MUL2: begin
            mul_x = (op_ff == OP_DIV) ? bm_ff : (op_ff == OP_MUL) ? bd_ff : bm_ff;
            mul_y = ad_ff;
         end
         S_COMBINE: begin
            mul_x = ad_ff;
            mul_y = bd_ff;
         end
         default: begin
            mul_x = am_ff;
            mul_y = bd_ff;
         end
      endcase
      mul_p = WideBits'(mul_x) * WideBits'(mul_y);
   end

   // gcd and divider units
   logic gcd_start, gcd_done, div_start, div_done;
   logic [WideBits-1:0] gcd_value, div_a, div_b, div_q, div_r;

   rau_gcd u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start),
      .x_value(m_ff), .y_value(d_ff), .done(gcd_done), .gcd_value(gcd_value)
   );

   rau_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done),
      .quotient(div_q), .remainder(div_r)
   );

   // divider passes: m/g as the gcd finishes, then d/g, then split m/d
   always_comb begin
      case (divstep_ff)
         2'd0: begin
            div_a = (state_ff == S_GCD) ? m_ff : d_ff;
            div_b = (state_ff == S_GCD) ? gcd_value : g_ff;
         end
         default: begin div_a = m_ff; div_b = d_ff; end
      endcase
   end

   logic req_fire, rsp_fire, zero_err;
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign zero_err = ad_w == '0 || (uses_b && bd_w == '0)
                     || (req.payload.operation == OP_DIV && bn_w == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req.payload.operation == OP_NONE || zero_err) state_in = S_DONE;
               else if (req.payload.operation == OP_NORM
                        || req.payload.operation == OP_SPLIT) state_in = S_MUL2;
               else state_in = S_MUL1;
            end
         end
         S_MUL1:    state_in = S_MUL2;
         S_MUL2:    state_in = S_COMBINE;
         S_COMBINE: state_in = (op_ff == OP_CMP) ? S_DONE : S_GCD;
         S_GCD:     if (gcd_done) state_in = S_DIVIDE;
         S_DIVIDE: begin
            if (div_done) begin
               if (divstep_ff == 2'd1) state_in = (op_ff == OP_SPLIT) ? S_SPLIT : S_CHECK;
               else if (divstep_ff == 2'd2) state_in = S_CHECK;
            end
         end
         S_SPLIT:   state_in = S_DIVIDE;
         S_CHECK:   state_in = S_DONE;
         S_DONE:    if (!valid_ff || rsp_fire) state_in = valid_ff ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // unit start strobes; the gcd starts once m and d are settled
   always_comb begin
      gcd_start = gcd_start_ff;
      div_start = (state_ff == S_GCD && gcd_done)
                  || (state_ff == S_DIVIDE && div_done && divstep_ff == 2'd0)
                  || state_ff == S_SPLIT;
   end

   // fit check on reduced magnitude and denominator
   logic fit_ok;
   always_comb begin
      fit_ok = d_ff <= Lim - 1 && (neg_ff ? m_ff <= Lim : m_ff <= Lim - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         gcd_start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gcd_start_ff <= state_ff == S_COMBINE && op_ff != OP_CMP;
         if (rsp_fire) valid_ff <= 1'b0;
         else if (state_ff == S_DONE && !valid_ff) valid_ff <= 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_ff <= req.payload.operation;
               am_ff <= an_mag;
               ad_ff <= ad_mag;
               an_ff <= an_neg ^ ad_neg && an_mag != '0;
               if (uses_b) begin
                  bm_ff <= bn_mag;
                  bd_ff <= bd_mag;
                  bn_ff <= (bn_neg ^ bd_neg && bn_mag != '0)
                           ^ (req.payload.operation == OP_SUB && bn_mag != '0);
               end else begin
                  bm_ff <= an_mag;
                  bd_ff <= ad_mag;
                  bn_ff <= 1'b0;
               end
               divstep_ff <= 2'd0;
               st_ff <= zero_err && req.payload.operation != OP_NONE ? ST_ZERO : ST_OK;
               res_num_ff <= '0;
               res_den_ff <= 31'd1;
               int_ff <= '0;
               lt_ff <= 1'b0;
               eq_ff <= 1'b0;
            end
         end
         S_MUL1: p_ff <= mul_p;
         S_MUL2: begin
            if (op_ff == OP_NORM || op_ff == OP_SPLIT) begin
               m_ff <= WideBits'(am_ff);
               d_ff <= WideBits'(ad_ff);
               neg_ff <= an_ff;
            end else if (op_ff == OP_MUL) begin
               m_ff <= p_ff;
               d_ff <= mul_p;
               neg_ff <= an_ff ^ bn_ff;
            end else if (op_ff == OP_DIV) begin
               m_ff <= p_ff;
               d_ff <= mul_p;
               neg_ff <= an_ff ^ bn_ff;
            end else begin
               q_ff <= mul_p;
            end
         end
         S_COMBINE: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               if (an_ff == bn_ff) begin
                  m_ff <= p_ff + q_ff;
                  neg_ff <= an_ff;
               end else if (p_ff >= q_ff) begin
                  m_ff <= p_ff - q_ff;
                  neg_ff <= an_ff;
               end else begin
                  m_ff <= q_ff - p_ff;
                  neg_ff <= bn_ff;
               end
               d_ff <= mul_p;
            end else if (op_ff == OP_CMP) begin
               // signed compare of the cross products
               if (an_ff != bn_ff) begin
                  lt_ff <= an_ff;
                  eq_ff <= 1'b0;
               end else begin
                  lt_ff <= an_ff ? p_ff > q_ff : p_ff < q_ff;
                  eq_ff <= p_ff == q_ff;
               end
            end
         end
         S_GCD: if (gcd_done) g_ff <= gcd_value;
         S_DIVIDE: begin
            if (div_done) begin
               if (divstep_ff == 2'd0) begin
                  m_ff <= div_q;
                  divstep_ff <= 2'd1;
               end else if (divstep_ff == 2'd1) begin
                  d_ff <= div_q;
                  divstep_ff <= 2'd2;
                  if (m_ff == '0) neg_ff <= 1'b0;
               end else begin
                  qm_ff <= div_q;
                  m_ff <= div_r;
                  if (div_r == '0) neg_ff <= 1'b0;
               end
            end
         end
         S_CHECK: begin
            if (op_ff == OP_SPLIT && qm_ff > (an_ff ? Lim : Lim - 1)) begin
               st_ff <= ST_OVF;
            end else if (!fit_ok) begin
               st_ff <= ST_OVF;
            end else begin
               res_num_ff <= neg_ff ? 32'(-m_ff) : 32'(m_ff);
               res_den_ff <= 31'(d_ff);
               if (op_ff == OP_SPLIT) int_ff <= an_ff ? 32'(-qm_ff) : 32'(qm_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // p and q for add, subtract and compare come from the two multiplier passes
   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = valid_ff;
   always_comb begin
      rsp.payload.res_num  = res_num_ff;
      rsp.payload.res_den  = res_den_ff;
      rsp.payload.int_part = int_ff;
      rsp.payload.status   = st_ff;
      rsp.payload.less     = lt_ff;
      rsp.payload.equal    = eq_ff;
   end
endmodule
`default_nettype wire

/* src/rau_checker.sv */
// port-level checks for the rational arithmetic unit, bound to the top level
`default_nettype none
module rau_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [30:0] rsp_res_den,
   input wire logic        rsp_less,
   input wire logic        rsp_equal
);
   // never takes a request while a response is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // denominator never zero
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_den != '0) else $error("zero denominator out");

   // less and equal never both set, clear on error
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_less && rsp_equal) && (rsp_status == 2'd0 || !rsp_less && !rsp_equal))
      else $error("bad compare flags");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.payload.status), .rsp_res_den(rsp.payload.res_den),
   .rsp_less(rsp.payload.less), .rsp_equal(rsp.payload.equal)
);
`default_nettype wire

/* bench/tb.sv */
// self-checking testbench for the rational arithmetic unit
`default_nettype none
module tb;
   import rau_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_payload_t;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic signed [31:0] int_part;
      status_type         status;
      logic               less;
      logic               equal;
   } rsp_payload_t;

   localparam longint unsigned WordLimit = 64'd1 << 31;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   error_count;
   rsp_payload_t expected_results[$];

   rau_if #(.payload_type(req_payload_t)) req_ch ();
   rau_if #(.payload_type(rsp_payload_t)) rsp_ch ();

   rational_arithmetic_unit uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // gcd of two magnitudes, gcd(0, d) = d
   function automatic longint unsigned gcd_of(input longint unsigned x, input longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // reduce sign and magnitude over a positive denominator, then check the word range
   function automatic status_type reduce_to_word(input bit neg, input longint unsigned m,
         input longint unsigned d, output longint num, output longint unsigned den);
      longint unsigned g;
      g = gcd_of(m, d);
      m = m / g;
      d = d / g;
      num = 0;
      den = 1;
      if (d > WordLimit - 1) return ST_OVF;
      if (neg && m != 0) begin
         if (m > WordLimit) return ST_OVF;
         num = -longint'(m);
      end else begin
         if (m > WordLimit - 1) return ST_OVF;
         num = longint'(m);
      end
      den = d;
      return ST_OK;
   endfunction

   // expected response for one request
   function automatic rsp_payload_t rational_result(input req_payload_t r);
      rsp_payload_t    o;
      longint          an, ad, bn, bd, num, ip, ps, qs;
      longint unsigned den, a_mag, a_dn, b_mag, b_dn, p, q, m, g, qm, rm, d;
      bit              a_neg, b_neg, bneg, neg, uses_b, lt, eq;
      status_type      st;
      an = r.a_num;
      ad = r.a_den;
      bn = r.b_num;
      bd = r.b_den;
      num = 0;
      ip = 0;
      den = 1;
      st = ST_OK;
      lt = 0;
      eq = 0;
      uses_b = (r.operation >= OP_ADD && r.operation <= OP_CMP);
      if (r.operation == OP_NONE) begin
      end else if (ad == 0 || (uses_b && bd == 0) || (r.operation == OP_DIV && bn == 0)) begin
         st = ST_ZERO;
      end else begin
         a_mag = (an < 0) ? longint'(-an) : an;
         a_dn = (ad < 0) ? longint'(-ad) : ad;
         a_neg = ((an < 0) != (ad < 0)) && a_mag != 0;
         if (uses_b) begin
            b_mag = (bn < 0) ? longint'(-bn) : bn;
            b_dn = (bd < 0) ? longint'(-bd) : bd;
            b_neg = ((bn < 0) != (bd < 0)) && b_mag != 0;
         end else begin
            b_mag = a_mag;
            b_dn = a_dn;
            b_neg = a_neg;
         end
         case (r.operation)
            OP_NORM: st = reduce_to_word(a_neg, a_mag, a_dn, num, den);
            OP_ADD, OP_SUB: begin
               bneg = (r.operation == OP_SUB) ? (!b_neg && b_mag != 0) : b_neg;
               p = a_mag * b_dn;
               q = b_mag * a_dn;
               if (a_neg == bneg) begin
                  m = p + q;
                  neg = a_neg;
               end else if (p >= q) begin
                  m = p - q;
                  neg = a_neg;
               end else begin
                  m = q - p;
                  neg = bneg;
               end
               st = reduce_to_word(neg && m != 0, m, a_dn * b_dn, num, den);
            end
            OP_MUL: begin
               m = a_mag * b_mag;
               st = reduce_to_word((a_neg != b_neg) && m != 0, m, a_dn * b_dn, num, den);
            end
            OP_DIV: begin
               m = a_mag * b_dn;
               st = reduce_to_word((a_neg != b_neg) && m != 0, m, a_dn * b_mag, num, den);
            end
            OP_CMP: begin
               ps = longint'(a_mag * b_dn);
               qs = longint'(b_mag * a_dn);
               if (a_neg) ps = -ps;
               if (b_neg) qs = -qs;
               lt = ps < qs;
               eq = ps == qs;
            end
            default: begin
               g = gcd_of(a_mag, a_dn);
               m = a_mag / g;
               d = a_dn / g;
               qm = m / d;
               rm = m % d;
               if (qm > (a_neg ? WordLimit : WordLimit - 1)) begin
                  st = ST_OVF;
               end else begin
                  ip = a_neg ? -longint'(qm) : longint'(qm);
                  st = reduce_to_word(a_neg && rm != 0, rm, d, num, den);
               end
            end
         endcase
      end
      if (st != ST_OK) begin
         num = 0;
         den = 1;
         ip = 0;
         lt = 0;
         eq = 0;
      end
      o.res_num = num[31:0];
      o.res_den = den[30:0];
      o.int_part = ip[31:0];
      o.status = st;
      o.less = lt;
      o.equal = eq;
      return o;
   endfunction

   // send one request, starting and ending at a falling edge
   task automatic send_request(input op_type op, input logic [31:0] an, input logic [31:0] ad,
         input logic [31:0] bn, input logic [31:0] bd);
      req_payload_t r;
      r.operation = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.payload = r;
      while (!req_ch.ready) @(negedge clock);
      expected_results.push_back(rational_result(r));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_ch.ready = 1'b0;
      else rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
         input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_payload_t e, a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.payload;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, actual %0h", $time, a);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            check_field("res_num", e.res_num, a.res_num);
            check_field("res_den", e.res_den, a.res_den);
            check_field("int_part", e.int_part, a.int_part);
            check_field("status", e.status, a.status);
            check_field("less", e.less, a.less);
            check_field("equal", e.equal, a.equal);
         end
      end
   end

   // operand value: often small, with extremes, powers of two, medium and full-range values
   function automatic logic [31:0] operand_value(input bit allow_zero);
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(40) - 20;
         4: case ($urandom_range(5))
               0: v = 32'h7fffffff;
               1: v = 32'h80000000;
               2: v = 32'h80000001;
               3: v = 32'd1;
               4: v = 32'hffffffff;
               default: v = 32'h40000000;
            endcase
         5: v = (32'd1 << $urandom_range(31)) * ($urandom_range(1) ? 1 : -1);
         6: v = $urandom_range(100000) * ($urandom_range(1) ? 1 : -1);
         default: v = $urandom;
      endcase
      if (!allow_zero && v == 0) v = 1;
      if (allow_zero && $urandom_range(99) < 3) v = 0;
      return v;
   endfunction

   task automatic random_requests(input int count);
      op_type op;
      repeat (count) begin
         op = op_type'($urandom_range(7));
         send_request(op, operand_value(1), operand_value(1), operand_value(1),
            operand_value(1));
      end
   endtask

   // extremes, each operation and each error case
   task automatic test_directed;
      send_request(OP_NORM, 32'd6, -32'sd4, 0, 1);
      send_request(OP_NORM, 32'h80000000, -32'sd1, 0, 1);
      send_request(OP_NORM, 32'h80000000, 32'd2, 0, 1);
      send_request(OP_NORM, 32'd0, -32'sd7, 0, 1);
      send_request(OP_NORM, 32'd5, 32'd0, 0, 0);
      send_request(OP_ADD, 32'd1, 32'd3, 32'd1, 32'd6);
      send_request(OP_ADD, 32'h7fffffff, 32'd1, 32'd1, 32'd1);
      send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
      send_request(OP_SUB, 32'd3, 32'd7, 32'd5, 32'd7);
      send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      send_request(OP_MUL, 32'h80000000, 32'd1, -32'sd1, 32'd1);
      send_request(OP_MUL, -32'sd4, 32'd9, 32'd3, -32'sd8);
      send_request(OP_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000001);
      send_request(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd5);
      send_request(OP_DIV, -32'sd2, 32'd3, 32'd4, -32'sd9);
      send_request(OP_DIV, 32'd1, 32'h7fffffff, 32'd2, 32'd1);
      send_request(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
      send_request(OP_CMP, -32'sd1, 32'd3, 32'd1, -32'sd4);
      send_request(OP_CMP, 32'h80000000, 32'd1, 32'h7fffffff, 32'h80000000);
      send_request(OP_SPLIT, -32'sd7, 32'd2, 0, 0);
      send_request(OP_SPLIT, 32'd7, -32'sd3, 0, 0);
      send_request(OP_SPLIT, 32'h80000000, 32'hffffffff, 0, 0);
      send_request(OP_SPLIT, 32'd9, 32'd3, 0, 0);
      send_request(OP_NONE, 32'd3, 32'd0, 32'd4, 32'd0);
   endtask

   task automatic test_no_idling;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_requests(160);
   endtask

   task automatic test_sender_idle;
      send_idle_pct = 82;
      rsp_stall_pct = 0;
      random_requests(160);
   endtask

   task automatic test_receiver_stall;
      send_idle_pct = 0;
      rsp_stall_pct = 82;
      random_requests(160);
   endtask

   // both sides idle, with a pause for the pipeline to drain midway
   task automatic test_both_idle;
      send_idle_pct = 35;
      rsp_stall_pct = 35;
      random_requests(80);
      wait (expected_results.size() == 0);
      @(negedge clock);
      random_requests(80);
   endtask

   // stimulus
   initial begin
      error_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      wait (expected_results.size() == 0);
      repeat (400) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // timeout
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
